[hdl/kvt_pkg.sv]
// Shared types and constants for the chained hash key/handle table.
// Used by kvt_bucket_store, kvt_way_match and the top level.
package kvt_pkg;

   localparam int Buckets = 64;
   localparam int Ways    = 4;
   localparam int KeyW    = 16;
   localparam int HandleW = 16;
   // Buckets is a power of two, so the bucket is the low key bits
   localparam int BucketW = $clog2(Buckets);

   typedef enum logic [0:0] {
      OP_INSERT = 1'b0,
      OP_LOOKUP = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_NOT_FOUND = 2'd2
   } status_type;

   typedef struct packed {
      op_type              op;
      logic [KeyW-1:0]     lookup_key;
      logic [HandleW-1:0]  entry_handle;
   } req_type;

   typedef struct packed {
      status_type          status;
      logic [HandleW-1:0]  found_handle;
   } rsp_type;

   typedef struct packed {
      logic [KeyW-1:0]     key;
      logic [HandleW-1:0]  handle;
   } slot_type;

   typedef slot_type [Ways-1:0] row_type;
   typedef logic [Ways-1:0]     valid_type;

   typedef struct packed {
      logic                en;
      logic [BucketW-1:0]  bucket;
      row_type             row;
      valid_type           valid;
   } row_wr_type;

endpackage

[hdl/kvt_bucket_store.sv]
// Bucket storage: one row of Ways slots per bucket, registered read with
// write-to-read forwarding, and per-slot valid flops cleared at reset. Uses kvt_pkg.
module kvt_bucket_store
   import kvt_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                rd_en,
   input  logic [BucketW-1:0]  rd_bucket,
   input  row_wr_type          row_wr,
   output row_type             rd_row,
   output valid_type           rd_valid
);

   row_type   mem_ff [Buckets];
   valid_type valid_ff [Buckets];
   row_type   rd_row_ff;
   valid_type rd_valid_ff;
   logic      fwd;

   assign fwd = row_wr.en && (row_wr.bucket == rd_bucket);

   always_ff @(posedge clock) begin
      if (row_wr.en) begin
         mem_ff[row_wr.bucket] <= row_wr.row;
      end
      if (rd_en) begin
         rd_row_ff <= fwd ? row_wr.row : mem_ff[rd_bucket];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int b = 0; b < Buckets; b++) begin
            valid_ff[b] <= '0;
         end
      end else if (row_wr.en) begin
         valid_ff[row_wr.bucket] <= row_wr.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_valid_ff <= fwd ? row_wr.valid : valid_ff[rd_bucket];
      end
   end

   assign rd_row   = rd_row_ff;
   assign rd_valid = rd_valid_ff;

endmodule

[hdl/kvt_way_match.sv]
// Per-request bucket logic: parallel key compare over the ways for lookups,
// head insert with shift for inserts. Purely combinational. Uses kvt_pkg.
module kvt_way_match
   import kvt_pkg::*;
(
   input  req_type    req,
   input  row_type    row,
   input  valid_type  valid,
   output rsp_type    rsp,
   output row_type    new_row,
   output valid_type  new_valid,
   output logic       do_write
);

   logic               hit;
   logic [HandleW-1:0] hit_handle;
   logic               full;

   // newest way wins: scan from tail to head, later hits override
   always_comb begin
      hit        = 1'b0;
      hit_handle = '0;
      for (int w = Ways - 1; w >= 0; w--) begin
         if (valid[w] && (row[w].key == req.lookup_key)) begin
            hit        = 1'b1;
            hit_handle = row[w].handle;
         end
      end
   end

   assign full = valid[Ways-1];

   always_comb begin
      new_row[0].key    = req.lookup_key;
      new_row[0].handle = req.entry_handle;
      new_valid[0]      = 1'b1;
      for (int w = 1; w < Ways; w++) begin
         new_row[w]   = row[w-1];
         new_valid[w] = valid[w-1];
      end
   end

   always_comb begin
      rsp.found_handle = '0;
      do_write         = 1'b0;
      if (req.op == OP_INSERT) begin
         if (full) begin
            rsp.status = STATUS_FULL;
         end else begin
            rsp.status = STATUS_OK;
            do_write   = 1'b1;
         end
      end else if (hit) begin
         rsp.status       = STATUS_OK;
         rsp.found_handle = hit_handle;
      end else begin
         rsp.status = STATUS_NOT_FOUND;
      end
   end

endmodule

[hdl/chained_hash_key_value_table_top.sv]
// Top level of the chained hash key/handle table: request stage, bucket store,
// way match and result register. Uses kvt_pkg, kvt_bucket_store, kvt_way_match.
//
// One request is taken every cycle (start high, busy low); busy is high only
// while reset is held. Each request gives exactly one result. rsp_strobe is high
// for one cycle per result. The bucket row read is registered on the accepting
// edge along with the request, way match works combinationally on both, and the
// result register then drives rsp_payload and rsp_strobe. A back-to-back request
// to the same bucket sees the previous insert through forwarding on the row
// read. Results come out in request order and cannot be held off. Valid marks
// clear in the reset cycle itself; no clearing pass follows.
module chained_hash_key_value_table_top
   import kvt_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   output logic     busy,
   input  req_type  req_payload,
   output logic     rsp_strobe,
   output rsp_type  rsp_payload
);

   logic       accept;
   logic       stage_valid_ff;
   req_type    stage_req_ff;
   logic       rsp_valid_ff;
   rsp_type    rsp_ff;
   row_type    rd_row;
   valid_type  rd_valid;
   rsp_type    match_rsp;
   row_type    new_row;
   valid_type  new_valid;
   logic       do_write;
   row_wr_type row_wr;

   assign busy   = reset;
   assign accept = start && !busy;

   kvt_bucket_store u_store (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (accept),
      .rd_bucket (req_payload.lookup_key[BucketW-1:0]),
      .row_wr    (row_wr),
      .rd_row    (rd_row),
      .rd_valid  (rd_valid)
   );

   kvt_way_match u_match (
      .req       (stage_req_ff),
      .row       (rd_row),
      .valid     (rd_valid),
      .rsp       (match_rsp),
      .new_row   (new_row),
      .new_valid (new_valid),
      .do_write  (do_write)
   );

   always_comb begin
      row_wr.en     = stage_valid_ff && do_write;
      row_wr.bucket = stage_req_ff.lookup_key[BucketW-1:0];
      row_wr.row    = new_row;
      row_wr.valid  = new_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= accept;
         rsp_valid_ff   <= stage_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_req_ff <= req_payload;
      end
      if (stage_valid_ff) begin
         rsp_ff <= match_rsp;
      end
   end

   assign rsp_strobe  = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_rsp_follows_request: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(accept, 2))
      else $error("result strobe without a request two cycles earlier");

   a_lookup_no_write: assert property (@(posedge clock) disable iff (reset)
      (stage_valid_ff && (stage_req_ff.op == OP_LOOKUP)) |-> !row_wr.en)
      else $error("lookup wrote the bucket store");

   a_miss_zero_handle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.status != STATUS_OK)) |-> (rsp_ff.found_handle == '0))
      else $error("failed request returned a nonzero handle");

endmodule

[test/tb_top.sv]
// Self-checking bench for chained_hash_key_value_table_top: directed table, then random requests.
// Needs kvt_pkg and the table RTL; a local model of the bucket store predicts the results of untyped rows.
`timescale 1ns / 1ps

module tb_top;
   import kvt_pkg::*;

   localparam int RandomCount = 1430;
   localparam int RecentMax   = 32;

   typedef struct {
      req_type  req;
      logic     typed;
      rsp_type  rsp;
   } dir_row_type;

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     start = 1'b0;
   logic     busy;
   req_type  req_payload = '0;
   logic     rsp_strobe;
   rsp_type  rsp_payload;

   // local copy of the bucket store, way 0 newest
   logic [KeyW-1:0]    model_key    [Buckets][Ways];
   logic [HandleW-1:0] model_handle [Buckets][Ways];
   logic               model_used   [Buckets][Ways];

   rsp_type          awaited_rsp[$];
   rsp_type          rsp_want;
   logic [KeyW-1:0]  recent_keys[$];
   logic [KeyW-1:0]  last_key = '0;
   int               mismatch_count = 0;
   dir_row_type      directed [21];

   chained_hash_key_value_table_top dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #1ms;
      $display("FAILURE");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      mismatch_count++;
   endtask

   // Applies one request to the local store and returns its result.
   function automatic rsp_type table_apply(input req_type r);
      rsp_type res;
      int      b;
      b = int'(r.lookup_key) % Buckets;
      res.status       = STATUS_OK;
      res.found_handle = '0;
      if (r.op == OP_INSERT) begin
         if (model_used[b][Ways-1]) begin
            res.status = STATUS_FULL;
         end else begin
            for (int w = Ways - 1; w > 0; w--) begin
               model_key[b][w]    = model_key[b][w-1];
               model_handle[b][w] = model_handle[b][w-1];
               model_used[b][w]   = model_used[b][w-1];
            end
            model_key[b][0]    = r.lookup_key;
            model_handle[b][0] = r.entry_handle;
            model_used[b][0]   = 1'b1;
         end
      end else begin
         res.status = STATUS_NOT_FOUND;
         // scan oldest to newest so the newest match wins
         for (int w = Ways - 1; w >= 0; w--) begin
            if (model_used[b][w] && model_key[b][w] == r.lookup_key) begin
               res.status       = STATUS_OK;
               res.found_handle = model_handle[b][w];
            end
         end
      end
      return res;
   endfunction

   function automatic req_type random_request();
      req_type r;
      int      pick;
      pick = $urandom_range(99);
      r.op = ($urandom_range(99) < 30) ? OP_INSERT : OP_LOOKUP;
      r.entry_handle = 16'($urandom);
      if (pick < 45 && recent_keys.size() > 0)
         r.lookup_key = recent_keys[$urandom_range(recent_keys.size() - 1)];
      else if (pick < 65)
         r.lookup_key = last_key + 16'(Buckets * $urandom_range(1, 3));  // same bucket
      else if (pick < 85)
         r.lookup_key = 16'($urandom_range(255));
      else
         r.lookup_key = 16'($urandom);
      return r;
   endfunction

   task automatic issue(input req_type r, input logic typed, input rsp_type given);
      rsp_type want;
      start       <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      want = table_apply(r);
      awaited_rsp.push_back(typed ? given : want);
      last_key = r.lookup_key;
      if (r.op == OP_INSERT) begin
         recent_keys.push_back(r.lookup_key);
         if (recent_keys.size() > RecentMax) void'(recent_keys.pop_front());
      end
   endtask

   task automatic maybe_idle(input logic allowed);
      if (allowed && $urandom_range(99) < 5) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   always @(posedge clock) begin
      if (rsp_strobe === 1'b1) begin
         if (awaited_rsp.size() == 0) begin
            report_mismatch("result with no request outstanding");
         end else begin
            rsp_want = awaited_rsp.pop_front();
            if (rsp_payload.status !== rsp_want.status)
               report_mismatch($sformatf("status %0d, expected %0d",
                                         rsp_payload.status, rsp_want.status));
            if (rsp_payload.found_handle !== rsp_want.found_handle)
               report_mismatch($sformatf("found_handle %h, expected %h",
                                         rsp_payload.found_handle, rsp_want.found_handle));
         end
      end
   end

   initial begin
      // bucket 0 gets filled, with a duplicate key, then overflowed
      directed = '{
         '{'{OP_LOOKUP, 16'h0000, 16'h1234}, 1'b1, '{STATUS_NOT_FOUND, 16'h0000}},
         '{'{OP_LOOKUP, 16'hFFFF, 16'hFFFF}, 1'b1, '{STATUS_NOT_FOUND, 16'h0000}},
         '{'{OP_INSERT, 16'h0000, 16'hFFFF}, 1'b1, '{STATUS_OK, 16'h0000}},
         '{'{OP_LOOKUP, 16'h0000, 16'h0000}, 1'b1, '{STATUS_OK, 16'hFFFF}},
         '{'{OP_INSERT, 16'h0040, 16'h0000}, 1'b1, '{STATUS_OK, 16'h0000}},
         '{'{OP_INSERT, 16'h0080, 16'h1234}, 1'b1, '{STATUS_OK, 16'h0000}},
         '{'{OP_INSERT, 16'h0000, 16'h5555}, 1'b1, '{STATUS_OK, 16'h0000}},
         '{'{OP_INSERT, 16'h00C0, 16'hAAAA}, 1'b1, '{STATUS_FULL, 16'h0000}},
         '{'{OP_LOOKUP, 16'h0000, 16'h0000}, 1'b0, '{STATUS_OK, 16'h0000}},
         '{'{OP_LOOKUP, 16'h0040, 16'h0000}, 1'b0, '{STATUS_OK, 16'h0000}},
         '{'{OP_LOOKUP, 16'h00C0, 16'h0000}, 1'b1, '{STATUS_NOT_FOUND, 16'h0000}},
         '{'{OP_LOOKUP, 16'h0100, 16'h0000}, 1'b0, '{STATUS_OK, 16'h0000}},
         '{'{OP_INSERT, 16'hFFFF, 16'h0000}, 1'b1, '{STATUS_OK, 16'h0000}},
         '{'{OP_LOOKUP, 16'hFFFF, 16'hFFFF}, 1'b0, '{STATUS_OK, 16'h0000}},
         '{'{OP_INSERT, 16'hFFFF, 16'hFFFF}, 1'b1, '{STATUS_OK, 16'h0000}},
         '{'{OP_LOOKUP, 16'hFFFF, 16'h0000}, 1'b0, '{STATUS_OK, 16'h0000}},
         '{'{OP_INSERT, 16'h8001, 16'h8000}, 1'b1, '{STATUS_OK, 16'h0000}},
         '{'{OP_LOOKUP, 16'h8001, 16'h0000}, 1'b0, '{STATUS_OK, 16'h0000}},
         '{'{OP_LOOKUP, 16'h0001, 16'h0000}, 1'b0, '{STATUS_OK, 16'h0000}},
         '{'{OP_INSERT, 16'h7FFF, 16'h7FFE}, 1'b1, '{STATUS_OK, 16'h0000}},
         '{'{OP_LOOKUP, 16'h7FFF, 16'h0000}, 1'b0, '{STATUS_OK, 16'h0000}}
      };
      for (int b = 0; b < Buckets; b++) begin
         for (int w = 0; w < Ways; w++) begin
            model_key[b][w]    = '0;
            model_handle[b][w] = '0;
            model_used[b][w]   = 1'b0;
         end
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i]) begin
         issue(directed[i].req, directed[i].typed, directed[i].rsp);
         maybe_idle(1'b1);
      end

      // requests 500..899 go back to back
      for (int n = 0; n < RandomCount; n++) begin
         issue(random_request(), 1'b0, '0);
         maybe_idle(n < 500 || n >= 900);
      end
      start <= 1'b0;

      while (awaited_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

[chained_hash_key_value_table_top.f]
hdl/kvt_pkg.sv
hdl/kvt_bucket_store.sv
hdl/kvt_way_match.sv
hdl/chained_hash_key_value_table_top.sv
test/tb_top.sv
